[src/setx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package setx_pkg;

    // Horizontal offset from raw position to screen column
    localparam logic [9:0] X_OFFSET   = 10'd71;
    // Top row before wrap: 256 - 7
    localparam logic [7:0] Y_TOP      = 8'd249;
    // Shift applied after the 8-bit vertical wrap
    localparam logic [8:0] Y_SHIFT    = 9'd32;
    // log2 of the cell edge in pixels
    localparam int unsigned CELL_LOG2 = 4;

    // Decoded sprite entry, held while its cells go out
    typedef struct packed {
        logic [8:0]        base;      // tile code with size bits cleared
        logic [5:0]        palette;
        logic              mirror_x;  // after screen flip
        logic              mirror_y;
        logic              wide;
        logic              tall;
        logic signed [9:0] sx;        // left column of the first cell
        logic signed [8:0] sy;        // top row of the first cell
    } t_sprite;

endpackage
`default_nettype wire

[src/setx_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module setx_decode (
    input  wire logic [7:0]        i_code_byte,
    input  wire logic [7:0]        i_color_byte,
    input  wire logic [7:0]        i_y_byte,
    input  wire logic [7:0]        i_x_byte,
    input  wire logic [7:0]        i_attr_byte,
    input  wire logic [7:0]        i_x_high_byte,
    input  wire logic              i_screen_flipped,
    output setx_pkg::t_sprite      o_sprite
);

    logic       wide;
    logic       tall;
    logic [8:0] code;
    logic [7:0] y_wrap;

    assign wide = i_attr_byte[2];
    assign tall = i_attr_byte[3];
    assign code = {i_attr_byte[7], i_code_byte};

    // top row wraps in 8 bits, tall sprites start one cell higher
    assign y_wrap = setx_pkg::Y_TOP - i_y_byte - {3'b000, tall, 4'b0000};

    always_comb begin
        o_sprite.base     = {code[8:2], code[1] & ~tall, code[0] & ~wide};
        o_sprite.palette  = i_color_byte[5:0];
        o_sprite.mirror_x = i_attr_byte[0] ^ i_screen_flipped;
        o_sprite.mirror_y = i_attr_byte[1] ^ i_screen_flipped;
        o_sprite.wide     = wide;
        o_sprite.tall     = tall;
        o_sprite.sx       = $signed({i_x_high_byte[0], i_x_byte} - setx_pkg::X_OFFSET);
        o_sprite.sy       = $signed({1'b0, y_wrap} - setx_pkg::Y_SHIFT);
    end

endmodule
`default_nettype wire

[src/sprite_entry_tile_expander.sv]
`timescale 1ns / 1ps
`default_nettype none
// Expands one six-byte sprite entry into one to four 16x16 cell draw commands,
// row by row and left to right. An entry is decoded into a holding register as
// it is accepted; a cell counter then moves one cell per cycle into the output
// register while the output is not stalled, and the next entry is taken in
// the cycle its last cell leaves the holding register. A stalled output holds
// both the output and the holding register.
// screen_flipped should only be written while no entry is in flight.
module sprite_entry_tile_expander (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire logic [7:0]        i_code_byte,
    input  wire logic [7:0]        i_color_byte,
    input  wire logic [7:0]        i_y_byte,
    input  wire logic [7:0]        i_x_byte,
    input  wire logic [7:0]        i_attr_byte,
    input  wire logic [7:0]        i_x_high_byte,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      logic [8:0]        o_tile_code,
    output      logic [5:0]        o_palette_select,
    output      logic              o_mirror_x,
    output      logic              o_mirror_y,
    output      logic signed [9:0] o_screen_x,
    output      logic signed [8:0] o_screen_y,
    output      logic              o_last_cell
);

    logic               r_flip;
    logic               r_a_valid;
    setx_pkg::t_sprite  r_spr;
    setx_pkg::t_sprite  dec_spr;
    logic               r_row, n_row;
    logic               r_col, n_col;
    logic               r_o_valid;

    logic               in_fire;
    logic               can_load;
    logic               a_last;
    logic               cell_r;
    logic               cell_c;

    // screen flip register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_flip <= i_cfg_wr_data;
        end
    end

    setx_decode u_decode (
        .i_code_byte      (i_code_byte),
        .i_color_byte     (i_color_byte),
        .i_y_byte         (i_y_byte),
        .i_x_byte         (i_x_byte),
        .i_attr_byte      (i_attr_byte),
        .i_x_high_byte    (i_x_high_byte),
        .i_screen_flipped (r_flip),
        .o_sprite         (dec_spr)
    );

    // handshake
    assign can_load = !r_o_valid || i_ready;
    assign a_last   = (r_row == r_spr.tall) && (r_col == r_spr.wide);
    assign o_ready  = !r_a_valid || (can_load && a_last);
    assign in_fire  = i_valid && o_ready;

    // cell counter: column first, then row
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (in_fire) begin
            n_row = 1'b0;
            n_col = 1'b0;
        end else if (r_a_valid && can_load && !a_last) begin
            if (r_col == r_spr.wide) begin
                n_col = 1'b0;
                n_row = 1'b1;
            end else begin
                n_col = 1'b1;
            end
        end
    end

    // holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_row     <= 1'b0;
            r_col     <= 1'b0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (can_load && a_last) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_spr <= dec_spr;
        end
    end

    // cell offset after mirroring, only along a doubled direction
    assign cell_r = r_row ^ (r_spr.tall & r_spr.mirror_y);
    assign cell_c = r_col ^ (r_spr.wide & r_spr.mirror_x);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (can_load) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && r_a_valid) begin
            o_tile_code      <= r_spr.base + {7'd0, cell_r, cell_c};
            o_palette_select <= r_spr.palette;
            o_mirror_x       <= r_spr.mirror_x;
            o_mirror_y       <= r_spr.mirror_y;
            o_screen_x       <= r_spr.sx
                                + $signed({5'd0, r_col, {setx_pkg::CELL_LOG2{1'b0}}});
            o_screen_y       <= r_spr.sy
                                + $signed({4'd0, r_row, {setx_pkg::CELL_LOG2{1'b0}}});
            o_last_cell      <= a_last;
        end
    end

    assign o_valid = r_o_valid;

    // counter never runs past the sprite's size
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> ((r_row <= r_spr.tall) && (r_col <= r_spr.wide)))
        else $error("cell counter beyond sprite size");

    // a fresh entry starts at the first cell
    a_cnt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_a_valid) |-> ((r_row == 1'b0) && (r_col == 1'b0)))
        else $error("entry did not start at first cell");

    // cells of one sprite follow without a gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_cell) |=> o_valid)
        else $error("gap between cells of one sprite");

endmodule
`default_nettype wire

[bench/sprite_entry_tile_expander_test.sv]
`timescale 1ns / 1ps
module sprite_entry_tile_expander_test;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_TICKS = 6;
    // position arithmetic, as the block defines it
    localparam logic [9:0] X_BIAS     = 10'd71;
    localparam logic [7:0] Y_TOP_RAW  = 8'd249;
    localparam logic [8:0] Y_BIAS     = 9'd32;
    localparam int         CELL_PIXELS = 16;

    // one six-byte sprite table entry
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] color;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] attr;
        logic [7:0] x_high;
    } t_sprite_entry;

    // one cell draw command
    typedef struct packed {
        logic [8:0]        tile;
        logic [5:0]        palette;
        logic              mirror_x;
        logic              mirror_y;
        logic signed [9:0] sx;
        logic signed [8:0] sy;
        logic              last;
    } t_cell_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic              i_cfg_wr_data;
    logic              i_valid;
    logic              o_ready;
    logic [7:0]        i_code_byte;
    logic [7:0]        i_color_byte;
    logic [7:0]        i_y_byte;
    logic [7:0]        i_x_byte;
    logic [7:0]        i_attr_byte;
    logic [7:0]        i_x_high_byte;
    logic              o_valid;
    logic              i_ready;
    logic [8:0]        o_tile_code;
    logic [5:0]        o_palette_select;
    logic              o_mirror_x;
    logic              o_mirror_y;
    logic signed [9:0] o_screen_x;
    logic signed [8:0] o_screen_y;
    logic              o_last_cell;

    t_cell_cmd   pending_cells[$];
    logic        flip_setting;
    int unsigned mismatch_count;
    int unsigned entries_sent;
    int unsigned cells_checked;
    int unsigned cycle_count;
    int unsigned src_gap_max;
    int unsigned sink_gap_max;

    sprite_entry_tile_expander dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_code_byte      (i_code_byte),
        .i_color_byte     (i_color_byte),
        .i_y_byte         (i_y_byte),
        .i_x_byte         (i_x_byte),
        .i_attr_byte      (i_attr_byte),
        .i_x_high_byte    (i_x_high_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_tile_code      (o_tile_code),
        .o_palette_select (o_palette_select),
        .o_mirror_x       (o_mirror_x),
        .o_mirror_y       (o_mirror_y),
        .o_screen_x       (o_screen_x),
        .o_screen_y       (o_screen_y),
        .o_last_cell      (o_last_cell)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Expand one entry into its cell commands, row by row, left to right
    function automatic void expand_entry(t_sprite_entry e);
        logic [8:0] base;
        logic       wide;
        logic       tall;
        logic       mx;
        logic       my;
        logic [9:0] left;
        logic [7:0] top_wrapped;
        logic [8:0] top;
        int         r;
        int         c;
        t_cell_cmd  cmd;
        base = {e.attr[7], e.code};
        wide = e.attr[2];
        tall = e.attr[3];
        mx   = e.attr[0] ^ flip_setting;
        my   = e.attr[1] ^ flip_setting;
        base[0] = base[0] & ~wide;
        base[1] = base[1] & ~tall;
        left = {1'b0, e.x_high[0], e.x} - X_BIAS;
        top_wrapped = Y_TOP_RAW - e.y - (tall ? 8'd16 : 8'd0);
        top = {1'b0, top_wrapped} - Y_BIAS;
        for (int row = 0; row <= int'(tall); row++) begin
            for (int col = 0; col <= int'(wide); col++) begin
                // mirroring only reorders cells along a doubled direction
                r = row ^ int'(tall & my);
                c = col ^ int'(wide & mx);
                cmd.tile     = base + 9'(2 * r + c);
                cmd.palette  = e.color[5:0];
                cmd.mirror_x = mx;
                cmd.mirror_y = my;
                cmd.sx       = left + 10'(CELL_PIXELS * col);
                cmd.sy       = top + 9'(CELL_PIXELS * row);
                cmd.last     = (row == int'(tall)) && (col == int'(wide));
                pending_cells.push_back(cmd);
            end
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (cell %0d)",
                 what, got, want, cells_checked);
        mismatch_count++;
    endtask

    // Present one entry after a random gap, predict it once taken
    task automatic send_entry(t_sprite_entry e);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap) begin
            @(negedge i_clk) i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_code_byte   = e.code;
        i_color_byte  = e.color;
        i_y_byte      = e.y;
        i_x_byte      = e.x;
        i_attr_byte   = e.attr;
        i_x_high_byte = e.x_high;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expand_entry(e);
        entries_sent++;
    endtask

    function automatic t_sprite_entry random_entry();
        t_sprite_entry e;
        e.code   = 8'($urandom);
        e.color  = 8'($urandom);
        e.y      = 8'($urandom);
        e.x      = 8'($urandom);
        e.attr   = 8'($urandom);
        e.x_high = 8'($urandom);
        return e;
    endfunction

    // Drop valid and wait until every expected cell has come out
    task automatic drain_cells();
        @(negedge i_clk) i_valid = 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_screen_flip(logic value);
        drain_cells();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk) i_cfg_wr_en = 1'b0;
        flip_setting = value;
    endtask

    // Every size and mirror combination, then position and code extremes
    task automatic test_directed_fields();
        t_sprite_entry e;
        for (int a = 0; a < 16; a++) begin
            e.code   = 8'(a * 37 + 3);
            e.color  = 8'(a * 16 + 5);
            e.y      = 8'(a * 16);
            e.x      = 8'(255 - a * 16);
            e.attr   = 8'(a) | ((a % 2 == 1) ? 8'h80 : 8'h70);
            e.x_high = (a % 4 >= 2) ? 8'hff : 8'hfe;
            send_entry(e);
        end
        send_entry('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_entry('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        // leftmost and rightmost columns
        send_entry('{8'h10, 8'hc0, 8'h40, 8'h00, 8'h04, 8'h00});
        send_entry('{8'h20, 8'h3f, 8'h40, 8'hff, 8'h04, 8'h01});
        // vertical wrap around the top and bottom of the range
        send_entry('{8'h30, 8'h01, 8'd249, 8'h80, 8'h00, 8'h00});
        send_entry('{8'h31, 8'h02, 8'd250, 8'h80, 8'h08, 8'h00});
        send_entry('{8'hff, 8'h2a, 8'd255, 8'h80, 8'h8f, 8'h00});
        drain_cells();
    endtask

    // Mirror and size combinations with the screen flipped
    task automatic test_flipped_mirrors();
        t_sprite_entry e;
        logic [3:0]    combos[8];
        combos = '{4'd0, 4'd3, 4'd5, 4'd6, 4'd9, 4'd10, 4'd12, 4'd15};
        set_screen_flip(1'b1);
        foreach (combos[k]) begin
            e = random_entry();
            e.attr[3:0] = combos[k];
            send_entry(e);
        end
        drain_cells();
    endtask

    task automatic test_random_entries(int unsigned count, int unsigned src_max,
                                       int unsigned sink_max);
        src_gap_max  = src_max;
        sink_gap_max = sink_max;
        repeat (count) send_entry(random_entry());
        drain_cells();
    endtask

    // Sink side: random hold-off before each cell is taken
    initial begin
        int unsigned gap;
        i_ready = 1'b0;
        forever begin
            gap = $urandom_range(0, sink_gap_max);
            repeat (gap) begin
                @(negedge i_clk) i_ready = 1'b0;
            end
            @(negedge i_clk) i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each cell taken with the oldest prediction
    always @(posedge i_clk) begin : check_cells
        t_cell_cmd want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected cell, tile", o_tile_code, -1);
            end else begin
                want = pending_cells.pop_front();
                if (o_tile_code !== want.tile)
                    report_mismatch("tile_code", o_tile_code, want.tile);
                if (o_palette_select !== want.palette)
                    report_mismatch("palette_select", o_palette_select, want.palette);
                if (o_mirror_x !== want.mirror_x)
                    report_mismatch("mirror_x", o_mirror_x, want.mirror_x);
                if (o_mirror_y !== want.mirror_y)
                    report_mismatch("mirror_y", o_mirror_y, want.mirror_y);
                if (o_screen_x !== want.sx)
                    report_mismatch("screen_x", o_screen_x, want.sx);
                if (o_screen_y !== want.sy)
                    report_mismatch("screen_y", o_screen_y, want.sy);
                if (o_last_cell !== want.last)
                    report_mismatch("last_cell", o_last_cell, want.last);
                cells_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d cells outstanding", pending_cells.size());
            $display("FAIL sprite_entry_tile_expander");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = 1'b0;
        i_valid        = 1'b0;
        i_code_byte    = '0;
        i_color_byte   = '0;
        i_y_byte       = '0;
        i_x_byte       = '0;
        i_attr_byte    = '0;
        i_x_high_byte  = '0;
        flip_setting   = 1'b0;
        mismatch_count = 0;
        entries_sent   = 0;
        cells_checked  = 0;
        cycle_count    = 0;
        src_gap_max    = 6;
        sink_gap_max   = 6;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        test_directed_fields();
        test_flipped_mirrors();
        test_random_entries(25, 6, 6);
        set_screen_flip(1'b0);
        test_random_entries(25, 6, 6);
        // back to back, then output back-pressure only
        test_random_entries(12, 0, 0);
        test_random_entries(10, 0, 6);
        set_screen_flip(1'b1);
        test_random_entries(7, 0, 0);

        $display("run covered %0d sprite entries and %0d cell commands,", entries_sent,
                 cells_checked);
        $display("screen flip off and on, with and without stalls on both sides");
        if (mismatch_count == 0) begin
            $display("PASS sprite_entry_tile_expander");
        end else begin
            $display("FAIL sprite_entry_tile_expander");
        end
        $finish;
    end

endmodule
